FILE: rtl/core/wsc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// wavetable sound channel. No dependencies.
`default_nettype none

package wsc_pkg;

    localparam int WAVE_ENTRIES    = 32;
    localparam int IDX_W           = $clog2(WAVE_ENTRIES);
    localparam int WAVE_BYTES      = WAVE_ENTRIES / 2;
    localparam int BYTE_IDX_W      = IDX_W - 1;
    localparam int LEN_TICK_CYCLES = 16384;
    localparam int RELOAD_W        = $clog2(256 * LEN_TICK_CYCLES + 1);
    localparam int LEFT_W          = RELOAD_W + 1;
    localparam int PERIOD_W        = 11;
    localparam int STEP_PERIOD_W   = 13;
    localparam int STEP_LEFT_W     = 14;

    localparam logic [STEP_PERIOD_W-1:0] STEP_BASE = STEP_PERIOD_W'(2 * 2048);

    // operation codes
    localparam logic [1:0] OP_REG     = 2'd0;
    localparam logic [1:0] OP_WAVE    = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    // control register indexes
    localparam logic [3:0] REG_DAC     = 4'd0;
    localparam logic [3:0] REG_LENGTH  = 4'd1;
    localparam logic [3:0] REG_LEVEL   = 4'd2;
    localparam logic [3:0] REG_FREQ_LO = 4'd3;
    localparam logic [3:0] REG_FREQ_HI = 4'd4;

    // readback masks
    localparam logic [7:0] RB_MASK_DAC     = 8'h80;
    localparam logic [7:0] RB_MASK_LEVEL   = 8'h60;
    localparam logic [7:0] RB_MASK_FREQ_HI = 8'h40;

    typedef struct packed {
        logic accept;
        logic step;
        logic load;
    } wsc_cmd_t;

    typedef struct packed {
        logic step_due;
    } wsc_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/wavetable_sound_channel_unit.sv
// An accepted input word is worked in ST_STEP: the sample index is stepped while
// a step is due (0 to 32 steps for an advance), then the result word is loaded
// once the output slot is free. A new word is accepted only in ST_IDLE, after that load.
// A finished result waits in the output register while the next word starts.
// Reset (rst_n, async, active low): channel stopped, all registers and the
// wave store cleared, no result pending.
`default_nettype none

module wavetable_sound_channel_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [3:0]  offset,
    input  wire logic [7:0]  data,
    input  wire logic [5:0]  cycles,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       readback,
    output logic signed [4:0] sample_out,
    output logic             running
);

    wsc_pkg::wsc_cmd_t    cmd;
    wsc_pkg::wsc_status_t status;

    wsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    wsc_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .op         (op),
        .offset     (offset),
        .data       (data),
        .cycles     (cycles),
        .status     (status),
        .readback   (readback),
        .sample_out (sample_out),
        .running    (running)
    );

endmodule

`default_nettype wire

FILE: rtl/core/wsc_ctrl.sv
// Controller for the wavetable sound channel: input/output handshake and
// sequencing of sample-index steps. Depends on wsc_pkg.
`default_nettype none

module wsc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    input  wire wsc_pkg::wsc_status_t status,
    output wsc_pkg::wsc_cmd_t         cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (status.step_due)
                begin
                    cmd.step = 1'b1;
                end
                else if (slot_free)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/core/wsc_datapath.sv
// Datapath for the wavetable sound channel: control registers, wave store,
// length and period counters, output word registers. Depends on wsc_pkg.
`default_nettype none

module wsc_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire wsc_pkg::wsc_cmd_t    cmd,
    input  wire logic [1:0]           op,
    input  wire logic [3:0]           offset,
    input  wire logic [7:0]           data,
    input  wire logic [5:0]           cycles,
    output wsc_pkg::wsc_status_t      status,
    output logic [7:0]                readback,
    output logic signed [4:0]         sample_out,
    output logic                      running
);

    logic                                   dac_enabled_reg, dac_enabled_next;
    logic                                   playing_reg, playing_next;
    logic                                   length_enabled_reg, length_enabled_next;
    logic [1:0]                             level_shift_reg, level_shift_next;
    logic [wsc_pkg::PERIOD_W-1:0]           period_code_reg, period_code_next;
    logic [wsc_pkg::RELOAD_W-1:0]           length_reload_reg, length_reload_next;
    logic [wsc_pkg::LEFT_W-1:0]             length_left_reg, length_left_next;
    logic [wsc_pkg::STEP_PERIOD_W-1:0]      step_period_reg, step_period_next;
    logic [wsc_pkg::STEP_LEFT_W-1:0]        step_left_reg, step_left_next;
    logic [wsc_pkg::IDX_W-1:0]              sample_index_reg, sample_index_next;
    logic [7:0]                             wave_reg [wsc_pkg::WAVE_BYTES];
    logic [7:0]                             wave_next [wsc_pkg::WAVE_BYTES];
    logic                                   walk_reg, walk_next;
    logic [7:0]                             rb_pend_reg, rb_pend_next;
    logic [7:0]                             readback_reg, readback_next;
    logic signed [4:0]                      sample_reg, sample_next;
    logic                                   running_reg, running_next;

    logic [wsc_pkg::LEFT_W-1:0]             len_dec;
    logic [wsc_pkg::STEP_LEFT_W-1:0]        step_dec;
    logic [wsc_pkg::PERIOD_W-1:0]           new_period;
    logic [wsc_pkg::STEP_PERIOD_W-1:0]      trig_period;
    logic [wsc_pkg::RELOAD_W-1:0]           reload_calc;
    logic [7:0]                             wave_byte;
    logic [3:0]                             nib;
    logic [3:0]                             lvl;

    assign len_dec     = length_left_reg - wsc_pkg::LEFT_W'(cycles);
    assign step_dec    = step_left_reg - wsc_pkg::STEP_LEFT_W'(cycles);
    assign new_period  = {data[2:0], period_code_reg[7:0]};
    assign trig_period = wsc_pkg::STEP_BASE - {1'b0, new_period, 1'b0};
    assign reload_calc = wsc_pkg::RELOAD_W'((9'd256 - {1'b0, data})
                         * wsc_pkg::LEN_TICK_CYCLES);

    assign wave_byte = wave_reg[sample_index_reg[wsc_pkg::IDX_W-1:1]];
    assign nib       = sample_index_reg[0] ? wave_byte[3:0] : wave_byte[7:4];
    assign lvl       = nib >> (level_shift_reg - 2'd1);

    assign status.step_due = walk_reg
        && (step_left_reg[wsc_pkg::STEP_LEFT_W-1] || (step_left_reg == '0));

    always_comb
    begin
        dac_enabled_next    = dac_enabled_reg;
        playing_next        = playing_reg;
        length_enabled_next = length_enabled_reg;
        level_shift_next    = level_shift_reg;
        period_code_next    = period_code_reg;
        length_reload_next  = length_reload_reg;
        length_left_next    = length_left_reg;
        step_period_next    = step_period_reg;
        step_left_next      = step_left_reg;
        sample_index_next   = sample_index_reg;
        wave_next           = wave_reg;
        walk_next           = walk_reg;
        rb_pend_next        = rb_pend_reg;
        readback_next       = readback_reg;
        sample_next         = sample_reg;
        running_next        = running_reg;

        if (cmd.accept)
        begin
            rb_pend_next = '0;
            walk_next    = 1'b0;
            case (op)
                wsc_pkg::OP_REG:
                begin
                    case (offset)
                        wsc_pkg::REG_DAC:
                        begin
                            dac_enabled_next = data[7];
                            rb_pend_next     = data & wsc_pkg::RB_MASK_DAC;
                        end
                        wsc_pkg::REG_LENGTH:
                        begin
                            length_reload_next = reload_calc;
                            length_left_next   = wsc_pkg::LEFT_W'(reload_calc);
                            rb_pend_next       = data;
                        end
                        wsc_pkg::REG_LEVEL:
                        begin
                            level_shift_next = data[6:5];
                            rb_pend_next     = data & wsc_pkg::RB_MASK_LEVEL;
                        end
                        wsc_pkg::REG_FREQ_LO:
                        begin
                            period_code_next[7:0] = data;
                            rb_pend_next          = data;
                        end
                        wsc_pkg::REG_FREQ_HI:
                        begin
                            period_code_next    = new_period;
                            length_enabled_next = data[6];
                            rb_pend_next        = data & wsc_pkg::RB_MASK_FREQ_HI;
                            if (data[7])
                            begin
                                length_left_next  = wsc_pkg::LEFT_W'(length_reload_reg);
                                step_period_next  = trig_period;
                                step_left_next    = wsc_pkg::STEP_LEFT_W'(trig_period);
                                sample_index_next = '0;
                                playing_next      = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                wsc_pkg::OP_WAVE:
                begin
                    wave_next[offset[wsc_pkg::BYTE_IDX_W-1:0]] = data;
                end
                wsc_pkg::OP_ADVANCE:
                begin
                    if (playing_reg)
                    begin
                        if (length_enabled_reg)
                        begin
                            length_left_next = len_dec;
                        end
                        if (length_enabled_reg
                            && (len_dec[wsc_pkg::LEFT_W-1] || (len_dec == '0)))
                        begin
                            playing_next = 1'b0;
                        end
                        else if (step_period_reg != '0)
                        begin
                            step_left_next = step_dec;
                            walk_next      = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.step)
        begin
            step_left_next    = step_left_reg + wsc_pkg::STEP_LEFT_W'(step_period_reg);
            sample_index_next = sample_index_reg + 1'b1;
        end

        if (cmd.load)
        begin
            readback_next = rb_pend_reg;
            running_next  = playing_reg;
            if (dac_enabled_reg && playing_reg && (level_shift_reg != 2'd0))
            begin
                // 2*s-15 in 5-bit two's complement
                sample_next = {~lvl[3], lvl[2:0], 1'b1};
            end
            else
            begin
                sample_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dac_enabled_reg    <= 1'b0;
            playing_reg        <= 1'b0;
            length_enabled_reg <= 1'b0;
            level_shift_reg    <= '0;
            period_code_reg    <= '0;
            length_reload_reg  <= '0;
            length_left_reg    <= '0;
            step_period_reg    <= '0;
            step_left_reg      <= '0;
            sample_index_reg   <= '0;
            for (int i = 0; i < wsc_pkg::WAVE_BYTES; i++)
            begin
                wave_reg[i] <= '0;
            end
            walk_reg           <= 1'b0;
            rb_pend_reg        <= '0;
            readback_reg       <= '0;
            sample_reg         <= '0;
            running_reg        <= 1'b0;
        end
        else
        begin
            dac_enabled_reg    <= dac_enabled_next;
            playing_reg        <= playing_next;
            length_enabled_reg <= length_enabled_next;
            level_shift_reg    <= level_shift_next;
            period_code_reg    <= period_code_next;
            length_reload_reg  <= length_reload_next;
            length_left_reg    <= length_left_next;
            step_period_reg    <= step_period_next;
            step_left_reg      <= step_left_next;
            sample_index_reg   <= sample_index_next;
            wave_reg           <= wave_next;
            walk_reg           <= walk_next;
            rb_pend_reg        <= rb_pend_next;
            readback_reg       <= readback_next;
            sample_reg         <= sample_next;
            running_reg        <= running_next;
        end
    end

    assign readback   = readback_reg;
    assign sample_out = sample_reg;
    assign running    = running_reg;

endmodule

`default_nettype wire

FILE: rtl/core/wsc_checker.sv
// Port-level assertions for wavetable_sound_channel_unit, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module wsc_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [7:0]        readback,
    input wire logic signed [4:0] sample_out,
    input wire logic              running
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(readback) && $stable(sample_out)
            && $stable(running))
        else $error("stalled result word changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled while a word is in work");

    a_silent_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !running |-> sample_out == 5'sd0)
        else $error("nonzero sample while stopped");

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_out != 5'b10000)
        else $error("sample out of range");

endmodule

bind wavetable_sound_channel_unit wsc_checker u_wsc_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for wavetable_sound_channel_unit: directed and random words
// go through a valid/stall driver, and a word-level channel predictor checks each result.
// Depends on wsc_pkg and the channel RTL.

module tb_top;

    import wsc_pkg::*;

    localparam logic [1:0] OP_IDLE      = 2'd3;
    localparam logic [3:0] REG_NONE_LO  = 4'd5;
    localparam logic [3:0] REG_NONE_HI  = 4'd15;
    localparam int         TOTAL_WORDS  = 1175;
    localparam int         HOLD_AFTER   = 400;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [1:0] op;
        logic [3:0] offset;
        logic [7:0] data;
        logic [5:0] cycles;
        int         gap;
        bit         drain;
    } word_t;

    typedef struct {
        logic [7:0]        readback;
        logic signed [4:0] sample;
        logic              running;
    } sound_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        op = '0;
    logic [3:0]        offset = '0;
    logic [7:0]        data = '0;
    logic [5:0]        cycles = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        readback;
    logic signed [4:0] sample_out;
    logic              running;

    word_t  feed_q[$];
    sound_t sound_due[$];
    word_t  cur;
    bit     have_cur;
    bit     word_taken;
    bit     result_taken;
    bit     hold_done;
    bit     quiet;
    int     gap_left;
    int     stall_left;
    int     n_words;
    int     results_seen;
    int     errors;
    int     cycle_cnt;

    // channel state
    bit         dac_on;
    bit         playing;
    bit         len_on;
    logic [1:0] level = '0;
    logic [10:0] period = '0;
    int         len_reload;
    int         len_left;
    int         step_per;
    int         step_left;
    logic [4:0] pos = '0;
    logic [3:0] wave [WAVE_ENTRIES] = '{default: 4'h0};

    wavetable_sound_channel_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .offset     (offset),
        .data       (data),
        .cycles     (cycles),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .readback   (readback),
        .sample_out (sample_out),
        .running    (running)
    );

    function automatic sound_t play_word(logic [1:0] w_op, logic [3:0] w_off,
                                         logic [7:0] w_dat, logic [5:0] w_cyc);
        sound_t r;
        r.readback = '0;
        r.sample = '0;
        case (w_op)
            OP_REG:
            begin
                case (w_off)
                    REG_DAC:
                    begin
                        dac_on = w_dat[7];
                        r.readback = w_dat & RB_MASK_DAC;
                    end
                    REG_LENGTH:
                    begin
                        len_reload = (256 - int'(w_dat)) * LEN_TICK_CYCLES;
                        len_left = len_reload;
                        r.readback = w_dat;
                    end
                    REG_LEVEL:
                    begin
                        level = w_dat[6:5];
                        r.readback = w_dat & RB_MASK_LEVEL;
                    end
                    REG_FREQ_LO:
                    begin
                        period[7:0] = w_dat;
                        r.readback = w_dat;
                    end
                    REG_FREQ_HI:
                    begin
                        period[10:8] = w_dat[2:0];
                        len_on = w_dat[6];
                        if (w_dat[7])
                        begin
                            len_left = len_reload;
                            step_per = int'(STEP_BASE) - 2 * int'(period);
                            step_left = step_per;
                            pos = '0;
                            playing = 1'b1;
                        end
                        r.readback = w_dat & RB_MASK_FREQ_HI;
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_WAVE:
            begin
                wave[{w_off, 1'b0}] = w_dat[7:4];
                wave[{w_off, 1'b1}] = w_dat[3:0];
            end
            OP_ADVANCE:
            begin
                if (playing && len_on)
                begin
                    len_left -= int'(w_cyc);
                    if (len_left <= 0)
                        playing = 1'b0;
                end
                if (playing && step_per > 0)
                begin
                    step_left -= int'(w_cyc);
                    while (step_left <= 0)
                    begin
                        step_left += step_per;
                        pos++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (dac_on && playing && level != 2'd0)
            r.sample = 5'(2 * (int'(wave[pos]) >> (level - 2'd1)) - 15);
        r.running = playing;
        return r;
    endfunction

    task automatic add_word(logic [1:0] w_op, logic [3:0] w_off, logic [7:0] w_dat,
                            logic [5:0] w_cyc);
        word_t w;
        w.op = w_op;
        w.offset = w_off;
        w.data = w_dat;
        w.cycles = w_cyc;
        w.gap = quiet ? 0 : $urandom_range(0, 8);
        w.drain = 1'b0;
        feed_q.push_back(w);
        n_words++;
    endtask

    task automatic add_pause();
        word_t w;
        w.op = OP_IDLE;
        w.offset = '0;
        w.data = '0;
        w.cycles = '0;
        w.gap = 0;
        w.drain = 1'b1;
        feed_q.push_back(w);
    endtask

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || word_taken)
            begin
                if (word_taken)
                    have_cur = 1'b0;
                word_taken = 1'b0;
                if (!have_cur && feed_q.size() != 0)
                begin
                    cur = feed_q.pop_front();
                    have_cur = 1'b1;
                    gap_left = cur.gap;
                end
                if (have_cur && cur.drain)
                begin
                    if (sound_due.size() == 0)
                        have_cur = 1'b0;
                    in_valid <= 1'b0;
                end
                else if (have_cur && gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (have_cur)
                begin
                    in_valid <= 1'b1;
                    op <= cur.op;
                    offset <= cur.offset;
                    data <= cur.data;
                    cycles <= cur.cycles;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result stall, with one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (result_taken)
                stall_left = ((results_seen / 64) % 4 == 1) ? 0 : $urandom_range(0, 8);
            result_taken = 1'b0;
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // result check, then prediction of the word taken at this edge
    always @(posedge clk)
    begin
        sound_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                result_taken = 1'b1;
                if (sound_due.size() == 0)
                begin
                    $error("result word with no word pending");
                    errors++;
                end
                else
                begin
                    want = sound_due.pop_front();
                    if (readback !== want.readback)
                    begin
                        $error("readback: expected %0h, got %0h", want.readback, readback);
                        errors++;
                    end
                    if (sample_out !== want.sample)
                    begin
                        $error("sample_out: expected %0d, got %0d", want.sample, sample_out);
                        errors++;
                    end
                    if (running !== want.running)
                    begin
                        $error("running: expected %0b, got %0b", want.running, running);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                word_taken = 1'b1;
                sound_due.push_back(play_word(op, offset, data, cycles));
            end
        end
    end

    initial
    begin
        int n;
        bit expiry_done;
        bit paused_mid;

        // stopped channel, op 3, registers above 4
        add_word(OP_ADVANCE, 4'd0, 8'h00, 6'd63);
        add_word(OP_IDLE, 4'd15, 8'hFF, 6'd63);
        add_word(OP_REG, REG_NONE_HI, 8'hFF, 6'd0);
        add_word(OP_REG, REG_NONE_LO, 8'hFF, 6'd0);
        add_word(OP_WAVE, 4'd0, 8'hF0, 6'd0);
        add_word(OP_WAVE, 4'd15, 8'h5A, 6'd0);
        add_word(OP_REG, REG_DAC, 8'hFF, 6'd0);
        add_word(OP_REG, REG_LEVEL, 8'h20, 6'd0);
        // length never written: stops at the first advance
        add_word(OP_REG, REG_FREQ_HI, 8'hC0, 6'd0);
        add_word(OP_ADVANCE, 4'd0, 8'h00, 6'd0);
        // fastest period
        add_word(OP_REG, REG_FREQ_LO, 8'hFF, 6'd0);
        add_word(OP_REG, REG_FREQ_HI, 8'h87, 6'd0);
        add_word(OP_ADVANCE, 4'd0, 8'h00, 6'd63);
        add_word(OP_ADVANCE, 4'd15, 8'hFF, 6'd63);
        add_word(OP_REG, REG_LEVEL, 8'h40, 6'd0);
        add_word(OP_REG, REG_LEVEL, 8'h60, 6'd0);
        add_word(OP_REG, REG_LENGTH, 8'hFF, 6'd0);
        add_word(OP_REG, REG_LENGTH, 8'h00, 6'd0);
        // period change without trigger
        add_word(OP_REG, REG_FREQ_LO, 8'h00, 6'd0);
        add_word(OP_ADVANCE, 4'd0, 8'h00, 6'd1);
        add_word(OP_REG, REG_FREQ_HI, 8'hC7, 6'd0);
        add_word(OP_WAVE, 4'd0, 8'h0F, 6'd0);
        add_word(OP_REG, REG_LEVEL, 8'h00, 6'd0);
        add_word(OP_REG, REG_DAC, 8'h00, 6'd0);
        add_word(OP_ADVANCE, 4'd0, 8'h00, 6'd63);
        add_pause();

        while (n_words < TOTAL_WORDS)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            if (!expiry_done && n_words >= 500)
            begin
                // run the length counter out
                expiry_done = 1'b1;
                add_word(OP_REG, REG_DAC, 8'h80, 6'($urandom));
                add_word(OP_REG, REG_LEVEL, 8'($urandom), 6'($urandom));
                add_word(OP_REG, REG_LENGTH, 8'hFF, 6'($urandom));
                add_word(OP_REG, REG_FREQ_HI, 8'hC0 | 8'($urandom_range(0, 7)), 6'($urandom));
                for (n = 0; n < 340; n++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        add_word(OP_WAVE, 4'($urandom), 8'($urandom), 6'($urandom));
                    else
                        add_word(OP_ADVANCE, 4'($urandom), 8'($urandom),
                                 6'($urandom_range(40, 63)));
                end
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                for (n = $urandom_range(5, 15); n > 0; n--)
                    add_word(2'($urandom), 4'($urandom), 8'($urandom), 6'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    add_word(OP_REG, REG_DAC, 8'($urandom), 6'($urandom));
                if ($urandom_range(0, 2) == 0)
                    add_word(OP_REG, REG_LENGTH, 8'($urandom), 6'($urandom));
                if ($urandom_range(0, 1) == 0)
                    add_word(OP_REG, REG_LEVEL, 8'($urandom), 6'($urandom));
                for (n = $urandom_range(0, 4); n > 0; n--)
                    add_word(OP_WAVE, 4'($urandom), 8'($urandom), 6'($urandom));
                add_word(OP_REG, REG_FREQ_LO, 8'($urandom), 6'($urandom));
                if ($urandom_range(0, 3) != 0)
                    add_word(OP_REG, REG_FREQ_HI, 8'($urandom) | 8'h80, 6'($urandom));
                else
                    add_word(OP_REG, REG_FREQ_HI, 8'($urandom), 6'($urandom));
                for (n = $urandom_range(4, 24); n > 0; n--)
                begin
                    if ($urandom_range(0, 7) == 0)
                        add_word(2'($urandom_range(0, 1)), 4'($urandom), 8'($urandom),
                                 6'($urandom));
                    else
                        add_word(OP_ADVANCE, 4'($urandom), 8'($urandom), 6'($urandom));
                end
            end
            if (!paused_mid && n_words >= 300)
            begin
                paused_mid = 1'b1;
                add_pause();
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || have_cur || in_valid || sound_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && sound_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
